// ===== rtl/cdc_pkg.sv =====
package cdc_pkg;

    localparam int LengthBits = 31;
    localparam int CfgIndexBits = 3;
    localparam int CfgDataBits = 31;

    typedef enum logic [CfgIndexBits-1:0] {
        REG_MIN_SIZE    = 3'd0,
        REG_AVG_SIZE    = 3'd1,
        REG_MAX_SIZE    = 3'd2,
        REG_STRICT_MASK = 3'd3,
        REG_LOOSE_MASK  = 3'd4,
        REG_EMIT_TAIL   = 3'd5
    } t_reg_index;

    typedef enum logic [2:0] {
        CUT_STRICT    = 3'd0,
        CUT_LOOSE     = 3'd1,
        CUT_MAX       = 3'd2,
        CUT_TAIL_EMIT = 3'd3,
        CUT_TAIL_KEEP = 3'd4
    } t_cut_kind;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       end_of_data;
    } t_in_item;

    typedef struct packed {
        logic [LengthBits-1:0] chunk_length;
        t_cut_kind             cut_kind;
    } t_out_item;

    typedef struct packed {
        logic [26:0]           min_size;
        logic [28:0]           center;
        logic [LengthBits-1:0] max_size;
        logic [30:0]           strict_mask;
        logic [30:0]           loose_mask;
        logic                  emit_tail;
    } t_cfg;

    localparam logic [31:0] HashWords [0:255] = '{
        32'd1553318008, 32'd574654857, 32'd759734804, 32'd310648967, 32'd1393527547,
        32'd1195718329, 32'd694400241, 32'd1154184075, 32'd1319583805, 32'd1298164590,
        32'd122602963, 32'd989043992, 32'd1918895050, 32'd933636724, 32'd1369634190,
        32'd1963341198, 32'd1565176104, 32'd1296753019, 32'd1105746212, 32'd1191982839,
        32'd1195494369, 32'd29065008, 32'd1635524067, 32'd722221599, 32'd1355059059,
        32'd564669751, 32'd1620421856, 32'd1100048288, 32'd1018120624, 32'd1087284781,
        32'd1723604070, 32'd1415454125, 32'd737834957, 32'd1854265892, 32'd1605418437,
        32'd1697446953, 32'd973791659, 32'd674750707, 32'd1669838606, 32'd320299026,
        32'd1130545851, 32'd1725494449, 32'd939321396, 32'd748475270, 32'd554975894,
        32'd1651665064, 32'd1695413559, 32'd671470969, 32'd992078781, 32'd1935142196,
        32'd1062778243, 32'd1901125066, 32'd1935811166, 32'd1644847216, 32'd744420649,
        32'd2068980838, 32'd1988851904, 32'd1263854878, 32'd1979320293, 32'd111370182,
        32'd817303588, 32'd478553825, 32'd694867320, 32'd685227566, 32'd345022554,
        32'd2095989693, 32'd1770739427, 32'd165413158, 32'd1322704750, 32'd46251975,
        32'd710520147, 32'd700507188, 32'd2104251000, 32'd1350123687, 32'd1593227923,
        32'd1756802846, 32'd1179873910, 32'd1629210470, 32'd358373501, 32'd807118919,
        32'd751426983, 32'd172199468, 32'd174707988, 32'd1951167187, 32'd1328704411,
        32'd2129871494, 32'd1242495143, 32'd1793093310, 32'd1721521010, 32'd306195915,
        32'd1609230749, 32'd1992815783, 32'd1790818204, 32'd234528824, 32'd551692332,
        32'd1930351755, 32'd110996527, 32'd378457918, 32'd638641695, 32'd743517326,
        32'd368806918, 32'd1583529078, 32'd1767199029, 32'd182158924, 32'd1114175764,
        32'd882553770, 32'd552467890, 32'd1366456705, 32'd934589400, 32'd1574008098,
        32'd1798094820, 32'd1548210079, 32'd821697741, 32'd601807702, 32'd332526858,
        32'd1693310695, 32'd136360183, 32'd1189114632, 32'd506273277, 32'd397438002,
        32'd620771032, 32'd676183860, 32'd1747529440, 32'd909035644, 32'd142389739,
        32'd1991534368, 32'd272707803, 32'd1905681287, 32'd1210958911, 32'd596176677,
        32'd1380009185, 32'd1153270606, 32'd1150188963, 32'd1067903737, 32'd1020928348,
        32'd978324723, 32'd962376754, 32'd1368724127, 32'd1133797255, 32'd1367747748,
        32'd1458212849, 32'd537933020, 32'd1295159285, 32'd2104731913, 32'd1647629177,
        32'd1691336604, 32'd922114202, 32'd170715530, 32'd1608833393, 32'd62657989,
        32'd1140989235, 32'd381784875, 32'd928003604, 32'd449509021, 32'd1057208185,
        32'd1239816707, 32'd525522922, 32'd476962140, 32'd102897870, 32'd132620570,
        32'd419788154, 32'd2095057491, 32'd1240747817, 32'd1271689397, 32'd973007445,
        32'd1380110056, 32'd1021668229, 32'd12064370, 32'd1186917580, 32'd1017163094,
        32'd597085928, 32'd2018803520, 32'd1795688603, 32'd1722115921, 32'd2015264326,
        32'd506263638, 32'd1002517905, 32'd1229603330, 32'd1376031959, 32'd763839898,
        32'd1970623926, 32'd1109937345, 32'd524780807, 32'd1976131071, 32'd905940439,
        32'd1313298413, 32'd772929676, 32'd1578848328, 32'd1108240025, 32'd577439381,
        32'd1293318580, 32'd1512203375, 32'd371003697, 32'd308046041, 32'd320070446,
        32'd1252546340, 32'd568098497, 32'd1341794814, 32'd1922466690, 32'd480833267,
        32'd1060838440, 32'd969079660, 32'd1836468543, 32'd2049091118, 32'd2023431210,
        32'd383830867, 32'd2112679659, 32'd231203270, 32'd1551220541, 32'd1377927987,
        32'd275637462, 32'd2110145570, 32'd1700335604, 32'd738389040, 32'd1688841319,
        32'd1506456297, 32'd1243730675, 32'd258043479, 32'd599084776, 32'd41093802,
        32'd792486733, 32'd1897397356, 32'd28077829, 32'd1520357900, 32'd361516586,
        32'd1119263216, 32'd209458355, 32'd45979201, 32'd363681532, 32'd477245280,
        32'd2107748241, 32'd601938891, 32'd244572459, 32'd1689418013, 32'd1141711990,
        32'd1485744349, 32'd1181066840, 32'd1950794776, 32'd410494836, 32'd1445347454,
        32'd2137242950, 32'd852679640, 32'd1014566730, 32'd1999335993, 32'd1871390758,
        32'd1736439305, 32'd231222289, 32'd603972436, 32'd783045542, 32'd370384393,
        32'd184356284, 32'd709706295, 32'd1453549767, 32'd591603172, 32'd768512391,
        32'd854125182
    };

endpackage

// ===== rtl/cdc_cfg.sv =====
module cdc_cfg (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [cdc_pkg::CfgIndexBits-1:0]    i_cfg_index,
    input  logic [cdc_pkg::CfgDataBits-1:0]     i_cfg_data,
    output cdc_pkg::t_cfg                       o_cfg
);

    logic [26:0]                   r_min_size;
    logic [28:0]                   r_avg_size;
    logic [28:0]                   r_center;
    logic [cdc_pkg::LengthBits-1:0] r_max_size;
    logic [30:0]                   r_strict_mask;
    logic [30:0]                   r_loose_mask;
    logic                          r_emit_tail;

    logic [26:0] n_min_size;
    logic [28:0] n_avg_size;
    logic [27:0] lead;
    logic [28:0] n_center;
    logic        wr_en;

    assign o_cfg_ready = 1'b1;
    assign wr_en = i_cfg_valid && o_cfg_ready;

    always_comb begin
        n_min_size = r_min_size;
        n_avg_size = r_avg_size;
        if (wr_en && i_cfg_index == cdc_pkg::REG_MIN_SIZE) begin
            n_min_size = i_cfg_data[26:0];
        end
        if (wr_en && i_cfg_index == cdc_pkg::REG_AVG_SIZE) begin
            n_avg_size = i_cfg_data[28:0];
        end
        // The lead is the minimum plus half the minimum, rounded up.
        lead = {1'b0, n_min_size} + {2'b0, n_min_size[26:1]} + {27'd0, n_min_size[0]};
        if ({1'b0, lead} > n_avg_size) begin
            n_center = '0;
        end else begin
            n_center = n_avg_size - {1'b0, lead};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min_size    <= 27'd2048;
            r_avg_size    <= 29'd8192;
            r_center      <= 29'd5120;
            r_max_size    <= 31'd65536;
            r_strict_mask <= 31'd16383;
            r_loose_mask  <= 31'd4095;
            r_emit_tail   <= 1'b0;
        end else if (wr_en) begin
            r_min_size <= n_min_size;
            r_avg_size <= n_avg_size;
            r_center   <= n_center;
            unique case (i_cfg_index)
                cdc_pkg::REG_MAX_SIZE:    r_max_size    <= i_cfg_data;
                cdc_pkg::REG_STRICT_MASK: r_strict_mask <= i_cfg_data;
                cdc_pkg::REG_LOOSE_MASK:  r_loose_mask  <= i_cfg_data;
                cdc_pkg::REG_EMIT_TAIL:   r_emit_tail   <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    assign o_cfg.min_size    = r_min_size;
    assign o_cfg.center      = r_center;
    assign o_cfg.max_size    = r_max_size;
    assign o_cfg.strict_mask = r_strict_mask;
    assign o_cfg.loose_mask  = r_loose_mask;
    assign o_cfg.emit_tail   = r_emit_tail;

endmodule

// ===== rtl/content_defined_chunker_core.sv =====
// Content-defined chunker: takes one byte per request and returns a result
// request only for bytes that close a chunk (strict or loose mask hit, forced
// maximum, or the tail on the end-of-data byte). It sustains one byte per
// clock cycle unless a result waits on a stalled output; byte and result are
// each registered, and the rolling hash's table read, add and mask test are
// combinational. Config writes are always ready and act on the next byte.
module content_defined_chunker_core (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [cdc_pkg::CfgIndexBits-1:0]    i_cfg_index,
    input  logic [cdc_pkg::CfgDataBits-1:0]     i_cfg_data,
    input  logic                                i_in_valid,
    output logic                                o_in_stall,
    input  cdc_pkg::t_in_item                   i_in,
    output logic                                o_out_valid,
    input  logic                                i_out_stall,
    output cdc_pkg::t_out_item                  o_out
);

    cdc_pkg::t_cfg cfg;

    logic                           r_in_valid;
    cdc_pkg::t_in_item              r_in;
    logic [31:0]                    r_hash;
    logic [cdc_pkg::LengthBits-1:0] r_pos;
    logic                           r_out_valid;
    cdc_pkg::t_out_item             r_out;

    logic [31:0]                    n_hash;
    logic [cdc_pkg::LengthBits-1:0] len;
    logic [30:0]                    mask;
    logic                           hashing;
    logic                           strict;
    logic                           has_result;
    logic                           fire;
    cdc_pkg::t_cut_kind             kind;

    cdc_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (cfg)
    );

    always_comb begin
        hashing = r_pos >= {4'd0, cfg.min_size};
        strict  = r_pos < {2'd0, cfg.center};
        n_hash  = {1'b0, r_hash[31:1]} + cdc_pkg::HashWords[r_in.data_byte];
        mask    = strict ? cfg.strict_mask : cfg.loose_mask;
        len     = r_pos + 31'd1;
        has_result = 1'b1;
        kind = cdc_pkg::CUT_MAX;
        if (hashing && (n_hash[30:0] & mask) == 31'd0) begin
            kind = strict ? cdc_pkg::CUT_STRICT : cdc_pkg::CUT_LOOSE;
        end else if (len >= cfg.max_size) begin
            kind = cdc_pkg::CUT_MAX;
        end else if (r_in.end_of_data) begin
            kind = cfg.emit_tail ? cdc_pkg::CUT_TAIL_EMIT : cdc_pkg::CUT_TAIL_KEEP;
        end else begin
            has_result = 1'b0;
        end
        fire = r_in_valid && (!has_result || !r_out_valid || !i_out_stall);
    end

    assign o_in_stall = r_in_valid && !fire;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_hash      <= '0;
            r_pos       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (!o_in_stall) begin
                r_in_valid <= i_in_valid;
            end
            if (fire) begin
                if (has_result) begin
                    r_hash <= '0;
                    r_pos  <= '0;
                end else begin
                    r_pos <= len;
                    if (hashing) begin
                        r_hash <= n_hash;
                    end
                end
            end
            if (fire && has_result) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && !o_in_stall) begin
            r_in <= i_in;
        end
        if (fire && has_result) begin
            r_out.chunk_length <= len;
            r_out.cut_kind     <= kind;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

endmodule

// ===== bench/content_defined_chunker_core_test.sv =====
module content_defined_chunker_core_test;

    localparam int ItemsPerPhase = 175;
    localparam int PhaseCount = 8;
    localparam int SettleCycles = 8;
    localparam int WatchdogLimit = 2000;
    localparam logic [30:0] AllOnes = 31'h7FFF_FFFF;

    typedef enum int {
        IDLE_NONE,
        IDLE_SENDER,
        IDLE_RECEIVER,
        IDLE_BOTH
    } t_idle_mode;

    logic                             i_clk;
    logic                             i_rst_n;
    logic                             i_cfg_valid;
    logic                             o_cfg_ready;
    logic [cdc_pkg::CfgIndexBits-1:0] i_cfg_index;
    logic [cdc_pkg::CfgDataBits-1:0]  i_cfg_data;
    logic                             i_in_valid;
    logic                             o_in_stall;
    cdc_pkg::t_in_item                i_in;
    logic                             o_out_valid;
    logic                             i_out_stall = 1'b0;
    cdc_pkg::t_out_item               o_out;

    // Local copy of the chunker state and its register file.
    logic [26:0] cfg_min;
    logic [28:0] cfg_avg;
    logic [30:0] cfg_max;
    logic [30:0] cfg_strict;
    logic [30:0] cfg_loose;
    logic        cfg_emit;
    logic [31:0] run_hash;
    logic [30:0] run_pos;

    cdc_pkg::t_out_item expected_cuts[$];
    int        sender_idle_pct = 0;
    int        receiver_stall_pct = 0;
    int        quiet_cycles = 0;
    bit        failed = 1'b0;

    content_defined_chunker_core DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in        (i_in),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out       (o_out)
    );

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    function automatic logic find_cut(input cdc_pkg::t_in_item item,
                                      output cdc_pkg::t_out_item cut);
        logic [31:0]        lead;
        logic [31:0]        center;
        logic [31:0]        len;
        logic               strict;
        logic               hit;
        cdc_pkg::t_cut_kind kind;
        lead = 32'(cfg_min) + ((32'(cfg_min) + 32'd1) >> 1);
        center = (lead > 32'(cfg_avg)) ? 32'd0 : 32'(cfg_avg) - lead;
        len = 32'(run_pos) + 32'd1;
        hit = 1'b0;
        kind = cdc_pkg::CUT_MAX;
        if (32'(run_pos) >= 32'(cfg_min)) begin
            strict = 32'(run_pos) < center;
            run_hash = (run_hash >> 1) + cdc_pkg::HashWords[item.data_byte];
            if ((run_hash & {1'b0, strict ? cfg_strict : cfg_loose}) == 32'd0) begin
                hit = 1'b1;
                kind = strict ? cdc_pkg::CUT_STRICT : cdc_pkg::CUT_LOOSE;
            end
        end
        if (!hit && len >= 32'(cfg_max)) begin
            hit = 1'b1;
            kind = cdc_pkg::CUT_MAX;
        end
        if (!hit && item.end_of_data) begin
            hit = 1'b1;
            kind = cfg_emit ? cdc_pkg::CUT_TAIL_EMIT : cdc_pkg::CUT_TAIL_KEEP;
        end
        cut.chunk_length = len[30:0];
        cut.cut_kind = kind;
        if (hit) begin
            run_hash = 32'd0;
            run_pos = '0;
        end else begin
            run_pos = len[30:0];
        end
        return hit;
    endfunction

    always @(posedge i_clk) begin
        i_out_stall <= ($urandom_range(99) < receiver_stall_pct);
    end

    always @(posedge i_clk) begin
        cdc_pkg::t_out_item want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (expected_cuts.size() == 0) begin
                $error("unexpected result: chunk_length %0d cut_kind %0d",
                       o_out.chunk_length, o_out.cut_kind);
                failed = 1'b1;
            end else begin
                want = expected_cuts.pop_front();
                if (o_out.chunk_length !== want.chunk_length) begin
                    $error("chunk_length expected %0d actual %0d",
                           want.chunk_length, o_out.chunk_length);
                    failed = 1'b1;
                end
                if (o_out.cut_kind !== want.cut_kind) begin
                    $error("cut_kind expected %0d actual %0d", want.cut_kind, o_out.cut_kind);
                    failed = 1'b1;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)
                || (i_cfg_valid && o_cfg_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles + 1 >= WatchdogLimit) begin
            $display("FAILURE");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    task automatic set_idling(input t_idle_mode mode);
        case (mode)
            IDLE_NONE: begin
                sender_idle_pct = 0;
                receiver_stall_pct = 0;
            end
            IDLE_SENDER: begin
                sender_idle_pct = 51;
                receiver_stall_pct = 0;
            end
            IDLE_RECEIVER: begin
                sender_idle_pct = 0;
                receiver_stall_pct = 51;
            end
            default: begin
                sender_idle_pct = 30;
                receiver_stall_pct = 30;
            end
        endcase
    endtask

    task automatic send_byte(input logic [7:0] data, input logic last);
        cdc_pkg::t_in_item  item;
        cdc_pkg::t_out_item cut;
        item = '{data_byte: data, end_of_data: last};
        while ($urandom_range(99) < sender_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in <= item;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        if (find_cut(item, cut)) expected_cuts.push_back(cut);
    endtask

    task automatic drain();
        i_in_valid <= 1'b0;
        while (expected_cuts.size() != 0) @(posedge i_clk);
        repeat (SettleCycles) @(posedge i_clk);
    endtask

    task automatic write_reg(input cdc_pkg::t_reg_index idx, input logic [30:0] value);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= value;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        case (idx)
            cdc_pkg::REG_MIN_SIZE:    cfg_min = value[26:0];
            cdc_pkg::REG_AVG_SIZE:    cfg_avg = value[28:0];
            cdc_pkg::REG_MAX_SIZE:    cfg_max = value;
            cdc_pkg::REG_STRICT_MASK: cfg_strict = value;
            cdc_pkg::REG_LOOSE_MASK:  cfg_loose = value;
            cdc_pkg::REG_EMIT_TAIL:   cfg_emit = value[0];
            default: ;
        endcase
    endtask

    task automatic load_settings(input logic [30:0] min_bytes, input logic [30:0] avg_bytes,
                                 input logic [30:0] max_bytes, input logic [30:0] strict,
                                 input logic [30:0] loose, input logic emit);
        write_reg(cdc_pkg::REG_MIN_SIZE, min_bytes);
        write_reg(cdc_pkg::REG_AVG_SIZE, avg_bytes);
        write_reg(cdc_pkg::REG_MAX_SIZE, max_bytes);
        write_reg(cdc_pkg::REG_STRICT_MASK, strict);
        write_reg(cdc_pkg::REG_LOOSE_MASK, loose);
        write_reg(cdc_pkg::REG_EMIT_TAIL, {30'd0, emit});
        i_cfg_valid <= 1'b0;
    endtask

    task automatic test_reset_defaults();
        send_byte(8'h00, 1'b1);
        send_byte(8'hFF, 1'b0);
        send_byte(8'h55, 1'b1);
        drain();
    endtask

    // Maximum below minimum, with an oversized minimum that must be cut to its width.
    task automatic test_forced_max();
        load_settings(AllOnes, 31'd0, 31'd3, 31'd0, 31'd0, 1'b1);
        send_byte(8'hAA, 1'b0);
        send_byte(8'h01, 1'b0);
        send_byte(8'h80, 1'b0);
        send_byte(8'h7F, 1'b1);
        drain();
    endtask

    // A maximum of zero closes every byte, and the forced cut wins over the tail.
    task automatic test_max_zero();
        load_settings(31'd5, 31'd0, 31'd0, 31'd0, 31'd0, 1'b0);
        send_byte(8'h12, 1'b0);
        send_byte(8'hED, 1'b1);
        drain();
    endtask

    task automatic test_mask_cuts();
        load_settings(31'd2, 31'd6, 31'd1000, 31'd0, AllOnes, 1'b0);
        send_byte(8'h00, 1'b0);
        send_byte(8'hFF, 1'b0);
        send_byte(8'h3C, 1'b0);
        // With a minimum of three the center is exactly three when rounding up.
        drain();
        load_settings(31'd3, 31'd8, 31'd1000, AllOnes, 31'd0, 1'b1);
        send_byte(8'h01, 1'b0);
        send_byte(8'h02, 1'b0);
        send_byte(8'h04, 1'b0);
        send_byte(8'h08, 1'b0);
        drain();
        // The mask test comes before both the forced cut and the tail.
        load_settings(31'd0, 31'd100, 31'd1, 31'd0, 31'd0, 1'b1);
        send_byte(8'h10, 1'b0);
        send_byte(8'hF0, 1'b1);
        drain();
    endtask

    task automatic pick_settings(input int phase, output int longest);
        logic [30:0] min_bytes;
        logic [30:0] avg_bytes;
        logic [30:0] max_bytes;
        logic [30:0] strict;
        logic [30:0] loose;
        longest = 40;
        if (phase == 0) begin
            load_settings(31'd64, 31'd256, 31'd1024, 31'd15, 31'd3, 1'b0);
            longest = 300;
        end else if (phase == 1) begin
            load_settings(31'h07FF_FFFF, 31'h1FFF_FFFF, AllOnes, AllOnes, AllOnes, 1'b1);
        end else begin
            min_bytes = ($urandom_range(9) == 0) ? 31'($urandom) : 31'($urandom_range(20));
            avg_bytes = ($urandom_range(9) == 0) ? 31'($urandom) : 31'($urandom_range(80));
            case ($urandom_range(9))
                0: max_bytes = 31'd0;
                1: max_bytes = 31'd1;
                2: max_bytes = AllOnes;
                default: max_bytes = 31'($urandom_range(100, 2));
            endcase
            strict = ($urandom_range(9) == 0) ? 31'($urandom)
                                              : (31'd1 << $urandom_range(7)) - 31'd1;
            loose = ($urandom_range(9) == 0) ? 31'($urandom)
                                             : (31'd1 << $urandom_range(6)) - 31'd1;
            load_settings(min_bytes, avg_bytes, max_bytes, strict, loose, 1'($urandom));
        end
    endtask

    task automatic test_random_streams();
        int sent;
        int len;
        int longest;
        bit closed;
        for (int phase = 0; phase < PhaseCount; phase++) begin
            pick_settings(phase, longest);
            set_idling(t_idle_mode'(phase % 4));
            sent = 0;
            while (sent < ItemsPerPhase) begin
                len = $urandom_range(longest, 1);
                if (len > ItemsPerPhase - sent) begin
                    len = ItemsPerPhase - sent;
                end
                // Most streams end with a marked last byte; a few run into the next.
                closed = ($urandom_range(7) != 0);
                for (int k = 0; k < len; k++) begin
                    send_byte(8'($urandom), closed && (k == len - 1));
                end
                sent += len;
            end
            drain();
            set_idling(IDLE_NONE);
        end
    endtask

    initial begin
        i_rst_n <= 1'b0;
        i_cfg_valid <= 1'b0;
        i_cfg_index <= cdc_pkg::REG_MIN_SIZE;
        i_cfg_data <= '0;
        i_in_valid <= 1'b0;
        i_in <= '0;
        cfg_min = 27'd2048;
        cfg_avg = 29'd8192;
        cfg_max = 31'd65536;
        cfg_strict = 31'd16383;
        cfg_loose = 31'd4095;
        cfg_emit = 1'b0;
        run_hash = 32'd0;
        run_pos = '0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_reset_defaults();
        test_forced_max();
        test_max_zero();
        test_mask_cuts();
        test_random_streams();
        if (!failed) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
rtl/cdc_pkg.sv
rtl/cdc_cfg.sv
rtl/content_defined_chunker_core.sv
bench/content_defined_chunker_core_test.sv
